// ----- src/sri_pkg.sv -----
// ----------------------------------------------------------------------------
// sri_pkg: shared types and constants of the sparse recurrent tanh tick block
// Geometry, request and status codes, fixed-point constants and the
// controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package sri_pkg;

  localparam int NODES      = 4096;
  localparam int EDGES      = 65536;
  localparam int DRIVE_ROWS = 2048;
  localparam int AGENTS     = 8;

  localparam int NODE_W  = $clog2(NODES);
  localparam int EDGE_W  = $clog2(EDGES);
  localparam int DRV_W   = $clog2(DRIVE_ROWS);
  localparam int LANE_W  = $clog2(AGENTS);
  localparam int NVAL_AW = 1 + NODE_W + LANE_W;
  localparam int DRV_AW  = DRV_W + LANE_W;
  localparam int ROWS_W  = NODE_W + 1;
  localparam int CFG_W   = 13;

  // request codes
  localparam logic [2:0] REQ_WR_EDGE  = 3'd0;
  localparam logic [2:0] REQ_WR_ROW   = 3'd1;
  localparam logic [2:0] REQ_WR_DRIVE = 3'd2;
  localparam logic [2:0] REQ_WR_STATE = 3'd3;
  localparam logic [2:0] REQ_RUN      = 3'd4;
  localparam logic [2:0] REQ_RD_STATE = 3'd5;
  localparam logic [2:0] REQ_CLEAR    = 3'd6;

  // result status codes
  localparam logic [1:0] STS_WRITE  = 2'd0;
  localparam logic [1:0] STS_RUN    = 2'd1;
  localparam logic [1:0] STS_READ   = 2'd2;
  localparam logic [1:0] STS_REJECT = 2'd3;

  // configuration register indexes
  localparam logic CFG_NODE_COUNT = 1'b0;
  localparam logic CFG_TICKS      = 1'b1;

  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 13'd4096;
  localparam logic [3:0]       TICKS_RST      = 4'd4;

  // fixed-point constants
  localparam logic [35:0]        LN2_Q30    = 36'd744261118;
  localparam logic [35:0]        LN2_HALF   = 36'd372130559;
  localparam logic [32:0]        TANH_CLIP  = 33'd589824;
  localparam logic signed [32:0] TAYLOR_C8  = 33'sd26631;
  localparam logic signed [63:0] ACC_LIM    = 64'sh4000_0000_0000_0000;

  function automatic logic signed [32:0] taylor_coef(input logic [2:0] k);
    logic signed [32:0] c;
    case (k)
      3'd0: c = 33'sd1073741824;
      3'd1: c = 33'sd1073741824;
      3'd2: c = 33'sd536870912;
      3'd3: c = 33'sd178956971;
      3'd4: c = 33'sd44739243;
      3'd5: c = 33'sd8947849;
      3'd6: c = 33'sd1491308;
      3'd7: c = 33'sd213044;
      default: c = 33'sd0;
    endcase
    return c;
  endfunction

  typedef struct packed {
    logic       req_load;
    logic       wr_edge;
    logic       wr_row;
    logic       wr_drive;
    logic       wr_state;
    logic       rd_state;
    logic       res_load;
    logic       res_read;
    logic [1:0] res_status;
    logic       clr_step;
    logic       bank_clr;
    logic       bank_flip;
    logic       tick_init;
    logic       row_rd;
    logic       row_latch;
    logic       lane_init;
    logic       edge_rd;
    logic       src_rd;
    logic       mul;
    logic       acc;
    logic       mag_sat;
    logic       mag_from_q;
    logic       div_start;
    logic       div_tanh;
    logic       pre_calc;
    logic       drv_add;
    logic       n_init;
    logic       n_step;
    logic       h_init;
    logic       h_mul;
    logic       h_add;
    logic       wb;
    logic       lane_next;
    logic       row_next;
  } sri_cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       addr_ok;
    logic       clr_last;
    logic       rows_done;
    logic       edges_done;
    logic       scale_sat;
    logic       div_busy;
    logic       n_done;
    logic       k_zero;
    logic       lane_last;
  } sri_stat_t;

endpackage

// ----- src/sparse_recurrent_tanh_tick.sv -----
// ----------------------------------------------------------------------------
// sparse_recurrent_tanh_tick: sparse recurrent graph update with tanh
// Top level: joins the controller and the datapath, exposes the word
// channels and the configuration write port.
// ----------------------------------------------------------------------------
// The block keeps a compressed-row sparse graph (edges, rows, drive rows) and
// two banks of eight signed Q16.16 lanes per node. Every input word yields
// exactly one result word. Load, read and bad-address words go from
// acceptance to result through accept, execute and present. A clear word and
// the start after reset both sweep all 65536 entries of the state memory one
// entry per cycle, with input stalled. A run word walks ticks_per_run ticks;
// each tick visits every active row and each of its eight lanes, and one lane
// takes an edge read, source read, multiply and accumulate per edge of the
// row, then the row scale division and the tanh (both through one shared
// radix-2 divider, the scale division skipped when the scaled sum saturates,
// the tanh using a range reduction and then a Horner series). The single
// ports of the edge and state memories set the per-edge cost. A finished
// result waits in an output register, so the next word is accepted while it
// is still stalled.
// ----------------------------------------------------------------------------
module sparse_recurrent_tanh_tick (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input word channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [2:0]                req_type_i,
  input  logic [15:0]               address_i,
  input  logic [2:0]                lane_i,
  input  logic [13:0]               edge_weight_i,
  input  logic [11:0]               edge_column_i,
  input  logic [16:0]               row_end_i,
  input  logic [30:0]               row_denominator_i,
  input  logic                      has_drive_i,
  input  logic [10:0]               drive_row_i,
  input  logic signed [31:0]        value_i,
  // result word channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [31:0]        read_value_o,
  output logic [1:0]                status_o,
  // configuration writes
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [sri_pkg::CFG_W-1:0] cfg_wdata_i
);

  sri_pkg::sri_cmd_t  cmd;
  sri_pkg::sri_stat_t st;

  // sequence every word and the walk over ticks, rows, lanes and edges
  sri_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_o       (cmd),
    .st_i        (st)
  );

  // hold the memories, do the arithmetic, hold the result word
  sri_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .req_type_i        (req_type_i),
    .address_i         (address_i),
    .lane_i            (lane_i),
    .edge_weight_i     (edge_weight_i),
    .edge_column_i     (edge_column_i),
    .row_end_i         (row_end_i),
    .row_denominator_i (row_denominator_i),
    .has_drive_i       (has_drive_i),
    .drive_row_i       (drive_row_i),
    .value_i           (value_i),
    .cmd_i             (cmd),
    .st_o              (st),
    .read_value_o      (read_value_o),
    .status_o          (status_o)
  );

`ifndef SYNTH
  // only a read word carries data
  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != sri_pkg::STS_READ) |-> read_value_o == 32'sd0)
    else $error("result data nonzero on a non-read word");

  // a result appears only after a word was in work
  a_res_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result word without work");

  // never overwrite a result word that is still stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_load |-> !(out_valid_o && out_stall_i))
    else $error("stalled result word overwritten");
`endif

endmodule

// ----- src/sri_div.sv -----
// ----------------------------------------------------------------------------
// sri_div: restoring divider
// Unsigned 64 by 32 division, one quotient bit per cycle. The
// caller keeps the quotient below 2^32.
// ----------------------------------------------------------------------------
module sri_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        busy_o,
  output logic [31:0] quotient_o
);

  logic [63:0] rem_q, dsh_q;
  logic [31:0] quo_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        ge;

  assign ge = rem_q >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      dsh_q <= {1'b0, divisor_i, 31'd0};
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= {quo_q[30:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ----- src/sri_dp.sv -----
// ----------------------------------------------------------------------------
// sri_dp: datapath
// Graph and state memories, edge walk counters, multiply-accumulate, row
// scaling, drive add, tanh approximation and the result register.
// ----------------------------------------------------------------------------
module sri_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [sri_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic [2:0]               req_type_i,
  input  logic [15:0]              address_i,
  input  logic [2:0]               lane_i,
  input  logic [13:0]              edge_weight_i,
  input  logic [11:0]              edge_column_i,
  input  logic [16:0]              row_end_i,
  input  logic [30:0]              row_denominator_i,
  input  logic                     has_drive_i,
  input  logic [10:0]              drive_row_i,
  input  logic signed [31:0]       value_i,
  input  sri_pkg::sri_cmd_t        cmd_i,
  output sri_pkg::sri_stat_t       st_o,
  output logic signed [31:0]       read_value_o,
  output logic [1:0]               status_o
);

  // latched request
  logic [2:0]         type_q;
  logic [15:0]        addr_q;
  logic [2:0]         lane_q;
  logic [13:0]        w_q;
  logic [11:0]        col_q;
  logic [16:0]        rend_q;
  logic [30:0]        rden_q;
  logic               has_q;
  logic [10:0]        drow_q;
  logic signed [31:0] val_q;

  logic [sri_pkg::CFG_W-1:0] node_count_q;
  logic                      bank_q;
  logic [sri_pkg::NVAL_AW-1:0] clr_cnt_q;

  // walk state
  logic [sri_pkg::ROWS_W-1:0] r_q;
  logic [sri_pkg::LANE_W-1:0] ln_q;
  logic [16:0] j_q, start_q, end_q;
  logic [30:0] den_q;
  logic [11:0] link_q;

  // arithmetic
  logic signed [46:0] prod_q;
  logic signed [63:0] acc_q;
  logic [31:0]        mag_q;
  logic signed [31:0] pre_q, x_q, old_q;
  logic               xneg_q;
  logic [35:0]        t_q;
  logic [4:0]         n_q;
  logic signed [30:0] s_q;
  logic signed [32:0] p_q;
  logic [2:0]         k_q;
  logic signed [63:0] hprod_q;

  logic signed [31:0] read_value_q;
  logic [1:0]         status_q;

  // memories
  logic [31:0] node_mem [2**sri_pkg::NVAL_AW];
  logic [25:0] edge_mem [sri_pkg::EDGES];
  logic [16:0] rend_mem [sri_pkg::NODES];
  logic [30:0] rden_mem [sri_pkg::NODES];
  logic [11:0] link_mem [sri_pkg::NODES];
  logic [31:0] drv_mem  [sri_pkg::DRIVE_ROWS * sri_pkg::AGENTS];

  logic [31:0] node_rd_q;
  logic [25:0] edge_rd_q;
  logic [16:0] rend_rd_q;
  logic [30:0] rden_rd_q;
  logic [11:0] link_rd_q;
  logic [31:0] drv_rd_q;

  logic                        nv_we, nv_re;
  logic [sri_pkg::NVAL_AW-1:0] nv_wa, nv_ra;
  logic [31:0]                 nv_wd;

  logic [sri_pkg::ROWS_W-1:0] rows;
  logic                       addr_ok;
  logic signed [63:0]         acc_sum;
  logic [63:0]                acc_abs;
  logic [63:0]                scale_dividend, tanh_dividend;
  logic signed [32:0]         drv_sum;
  logic [32:0]                ax;
  logic [19:0]                a20;
  logic signed [32:0]         e_s;
  logic signed [33:0]         num_s, den_s;
  logic [30:0]                num_u;
  logic [31:0]                den_u;
  logic signed [32:0]         tanh_s, new_sum;
  logic                       div_busy;
  logic [31:0]                div_q;

  sri_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (cmd_i.div_tanh ? tanh_dividend : scale_dividend),
    .divisor_i  (cmd_i.div_tanh ? den_u : {1'b0, den_q}),
    .busy_o     (div_busy),
    .quotient_o (div_q)
  );

  // range checks of the latched request
  always_comb begin
    case (type_q)
      sri_pkg::REQ_WR_EDGE:  addr_ok = int'(addr_q) < sri_pkg::EDGES;
      sri_pkg::REQ_WR_ROW:   addr_ok = (int'(addr_q) < sri_pkg::NODES) &&
                                       !(has_q && int'(drow_q) >= sri_pkg::DRIVE_ROWS);
      sri_pkg::REQ_WR_DRIVE: addr_ok = (int'(addr_q) < sri_pkg::DRIVE_ROWS) &&
                                       (int'(lane_q) < sri_pkg::AGENTS);
      sri_pkg::REQ_WR_STATE,
      sri_pkg::REQ_RD_STATE: addr_ok = (int'(addr_q) < sri_pkg::NODES) &&
                                       (int'(lane_q) < sri_pkg::AGENTS);
      default:               addr_ok = 1'b0;
    endcase
  end

  assign rows = (int'(node_count_q) > sri_pkg::NODES) ?
                sri_pkg::ROWS_W'(sri_pkg::NODES) : sri_pkg::ROWS_W'(node_count_q);

  // accumulate with saturation at +-2^62
  always_comb begin
    acc_sum = acc_q + prod_q;
    if (acc_sum > sri_pkg::ACC_LIM) begin
      acc_sum = sri_pkg::ACC_LIM;
    end else if (acc_sum < -sri_pkg::ACC_LIM) begin
      acc_sum = -sri_pkg::ACC_LIM;
    end
  end

  assign acc_abs        = acc_q[63] ? (64'd0 - 64'(acc_q)) : 64'(acc_q);
  assign scale_dividend = {2'd0, acc_abs[46:0], 15'd0};

  assign drv_sum = {pre_q[31], pre_q} + {drv_rd_q[31], drv_rd_q};

  assign ax  = x_q[31] ? (33'd0 - {x_q[31], x_q}) : {1'b0, x_q};
  assign a20 = (ax > sri_pkg::TANH_CLIP) ? sri_pkg::TANH_CLIP[19:0] : ax[19:0];

  // exp(-2a) = p / 2^n, then (1 - e) / (1 + e) rounded
  always_comb begin
    e_s   = p_q >>> n_q;
    num_s = 34'sd1073741824 - 34'(e_s);
    den_s = 34'sd1073741824 + 34'(e_s);
    num_u = num_s[33] ? '0 : num_s[30:0];
    den_u = den_s[31:0];
  end
  assign tanh_dividend = {17'd0, num_u, 16'd0} + {33'd0, den_u[31:1]};

  assign tanh_s  = xneg_q ? -$signed({16'd0, div_q[16:0]}) : $signed({16'd0, div_q[16:0]});
  assign new_sum = {old_q[31], old_q} + tanh_s;

  // state memory ports
  always_comb begin
    nv_we = 1'b0;
    nv_wa = '0;
    nv_wd = '0;
    if (cmd_i.clr_step) begin
      nv_we = 1'b1;
      nv_wa = clr_cnt_q;
    end else if (cmd_i.wr_state) begin
      nv_we = 1'b1;
      nv_wa = {bank_q, addr_q[sri_pkg::NODE_W-1:0], lane_q[sri_pkg::LANE_W-1:0]};
      nv_wd = val_q;
    end else if (cmd_i.wb) begin
      nv_we = 1'b1;
      nv_wa = {~bank_q, r_q[sri_pkg::NODE_W-1:0], ln_q};
      nv_wd = new_sum[32:1];
    end
  end

  always_comb begin
    nv_re = cmd_i.rd_state | cmd_i.src_rd | cmd_i.pre_calc;
    if (cmd_i.rd_state) begin
      nv_ra = {bank_q, addr_q[sri_pkg::NODE_W-1:0], lane_q[sri_pkg::LANE_W-1:0]};
    end else if (cmd_i.src_rd) begin
      nv_ra = {bank_q, edge_rd_q[sri_pkg::NODE_W-1:0], ln_q};
    end else begin
      nv_ra = {bank_q, r_q[sri_pkg::NODE_W-1:0], ln_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (nv_we) begin
      node_mem[nv_wa] <= nv_wd;
    end
    if (nv_re) begin
      node_rd_q <= node_mem[nv_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_edge) begin
      edge_mem[addr_q[sri_pkg::EDGE_W-1:0]] <= {w_q, col_q};
    end
    if (cmd_i.edge_rd) begin
      edge_rd_q <= edge_mem[j_q[sri_pkg::EDGE_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_row) begin
      rend_mem[addr_q[sri_pkg::NODE_W-1:0]] <= rend_q;
      rden_mem[addr_q[sri_pkg::NODE_W-1:0]] <= rden_q;
      link_mem[addr_q[sri_pkg::NODE_W-1:0]] <= has_q ? {1'b1, drow_q} : 12'd0;
    end
    if (cmd_i.row_rd) begin
      rend_rd_q <= rend_mem[r_q[sri_pkg::NODE_W-1:0]];
      rden_rd_q <= rden_mem[r_q[sri_pkg::NODE_W-1:0]];
      link_rd_q <= link_mem[r_q[sri_pkg::NODE_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_drive) begin
      drv_mem[{addr_q[sri_pkg::DRV_W-1:0], lane_q[sri_pkg::LANE_W-1:0]}] <= val_q;
    end
    if (cmd_i.pre_calc) begin
      drv_rd_q <= drv_mem[{link_q[sri_pkg::DRV_W-1:0], ln_q}];
    end
  end

  // control state of the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= sri_pkg::NODE_COUNT_RST;
      bank_q       <= 1'b0;
      clr_cnt_q    <= '0;
      r_q          <= '0;
      ln_q         <= '0;
      j_q          <= '0;
      start_q      <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == sri_pkg::CFG_NODE_COUNT) begin
        node_count_q <= cfg_wdata_i;
      end
      if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.bank_clr) begin
        bank_q <= 1'b0;
      end else if (cmd_i.bank_flip) begin
        bank_q <= ~bank_q;
      end
      if (cmd_i.tick_init) begin
        r_q     <= '0;
        start_q <= '0;
      end
      if (cmd_i.row_latch) begin
        ln_q <= '0;
      end
      if (cmd_i.lane_init) begin
        j_q <= start_q;
      end
      if (cmd_i.acc) begin
        j_q <= j_q + 17'd1;
      end
      if (cmd_i.lane_next) begin
        ln_q <= ln_q + 1'b1;
      end
      if (cmd_i.row_next) begin
        r_q <= r_q + 1'b1;
        if (end_q > start_q) begin
          start_q <= end_q;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      type_q <= req_type_i;
      addr_q <= address_i;
      lane_q <= lane_i;
      w_q    <= edge_weight_i;
      col_q  <= edge_column_i;
      rend_q <= row_end_i;
      rden_q <= row_denominator_i;
      has_q  <= has_drive_i;
      drow_q <= drive_row_i;
      val_q  <= value_i;
    end
    if (cmd_i.row_latch) begin
      end_q  <= (int'(rend_rd_q) > sri_pkg::EDGES) ? 17'(sri_pkg::EDGES) : rend_rd_q;
      den_q  <= (rden_rd_q == '0) ? 31'd1 : rden_rd_q;
      link_q <= link_rd_q;
    end
    if (cmd_i.lane_init) begin
      acc_q <= '0;
    end else if (cmd_i.acc) begin
      acc_q <= acc_sum;
    end
    if (cmd_i.mul) begin
      prod_q <= $signed({1'b0, edge_rd_q[25:12]}) * $signed(node_rd_q);
    end
    if (cmd_i.mag_sat) begin
      mag_q <= 32'h8000_0000;
    end else if (cmd_i.mag_from_q) begin
      mag_q <= div_q;
    end
    if (cmd_i.pre_calc) begin
      if (acc_q[63]) begin
        pre_q <= $signed(32'd0 - mag_q);
      end else begin
        pre_q <= mag_q[31] ? 32'sh7fff_ffff : $signed(mag_q);
      end
    end
    if (cmd_i.drv_add) begin
      old_q <= $signed(node_rd_q);
      // a link always names a stored drive row
      if (link_q[11]) begin
        if (drv_sum > 33'sh0_7fff_ffff) begin
          x_q <= 32'sh7fff_ffff;
        end else if (drv_sum < -33'sh0_8000_0000) begin
          x_q <= 32'sh8000_0000;
        end else begin
          x_q <= drv_sum[31:0];
        end
      end else begin
        x_q <= pre_q;
      end
    end
    if (cmd_i.n_init) begin
      xneg_q <= x_q[31];
      t_q    <= {1'b0, a20, 15'd0} + sri_pkg::LN2_HALF;
      n_q    <= '0;
    end else if (cmd_i.n_step) begin
      t_q <= t_q - sri_pkg::LN2_Q30;
      n_q <= n_q + 5'd1;
    end
    if (cmd_i.h_init) begin
      s_q <= $signed({1'b0, sri_pkg::LN2_HALF[29:0]}) - $signed({1'b0, t_q[29:0]});
      p_q <= sri_pkg::TAYLOR_C8;
      k_q <= 3'd7;
    end else if (cmd_i.h_add) begin
      p_q <= 33'(hprod_q >>> 30) + sri_pkg::taylor_coef(k_q);
      k_q <= k_q - 3'd1;
    end
    if (cmd_i.h_mul) begin
      hprod_q <= p_q * s_q;
    end
    if (cmd_i.res_load) begin
      read_value_q <= cmd_i.res_read ? $signed(node_rd_q) : 32'sd0;
      status_q     <= cmd_i.res_status;
    end
  end

  always_comb begin
    st_o            = '0;
    st_o.req_type   = type_q;
    st_o.addr_ok    = addr_ok;
    st_o.clr_last   = &clr_cnt_q;
    st_o.rows_done  = r_q == rows;
    st_o.edges_done = j_q >= end_q;
    st_o.scale_sat  = acc_abs[62:0] >= {16'd0, den_q, 16'd0};
    st_o.div_busy   = div_busy;
    st_o.n_done     = t_q < sri_pkg::LN2_Q30;
    st_o.k_zero     = k_q == 3'd0;
    st_o.lane_last  = int'(ln_q) == sri_pkg::AGENTS - 1;
  end

  assign read_value_o = read_value_q;
  assign status_o     = status_q;

endmodule

// ----- src/sri_ctrl.sv -----
// ----------------------------------------------------------------------------
// sri_ctrl: controller
// Sequences request execution, the tick/row/lane/edge walk, the scaling and
// tanh steps, the state clearing sweep and the result handshake.
// ----------------------------------------------------------------------------
module sri_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [sri_pkg::CFG_W-1:0] cfg_wdata_i,
  output sri_pkg::sri_cmd_t        cmd_o,
  input  sri_pkg::sri_stat_t       st_i
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_CLR_BOOT = 5'd1;
  localparam logic [4:0] S_CLR_REQ  = 5'd2;
  localparam logic [4:0] S_EXEC     = 5'd3;
  localparam logic [4:0] S_DONE     = 5'd4;
  localparam logic [4:0] S_T_START  = 5'd5;
  localparam logic [4:0] S_ROW_RD   = 5'd6;
  localparam logic [4:0] S_ROW_LAT  = 5'd7;
  localparam logic [4:0] S_LANE_ST  = 5'd8;
  localparam logic [4:0] S_E_RD     = 5'd9;
  localparam logic [4:0] S_E_LAT    = 5'd10;
  localparam logic [4:0] S_E_MUL    = 5'd11;
  localparam logic [4:0] S_E_ACC    = 5'd12;
  localparam logic [4:0] S_SCALE    = 5'd13;
  localparam logic [4:0] S_SDIV     = 5'd14;
  localparam logic [4:0] S_PRE      = 5'd15;
  localparam logic [4:0] S_DRV      = 5'd16;
  localparam logic [4:0] S_NINIT    = 5'd17;
  localparam logic [4:0] S_NLOOP    = 5'd18;
  localparam logic [4:0] S_HMUL     = 5'd19;
  localparam logic [4:0] S_HADD     = 5'd20;
  localparam logic [4:0] S_EXP      = 5'd21;
  localparam logic [4:0] S_TDIV     = 5'd22;
  localparam logic [4:0] S_WB       = 5'd23;
  localparam logic [4:0] S_TICK_END = 5'd24;

  logic [4:0] state_q, state_d;
  logic [3:0] ticks_q, tick_cnt_q, tick_cnt_d;
  logic [1:0] res_status_q, res_status_d;
  logic       res_read_q, res_read_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    cmd_o        = '0;
    state_d      = state_q;
    tick_cnt_d   = tick_cnt_q;
    res_status_d = res_status_q;
    res_read_d   = res_read_q;
    out_valid_d  = out_valid_q && out_stall_i;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d        = S_EXEC;
        end
      end
      S_CLR_BOOT: begin
        cmd_o.clr_step = 1'b1;
        if (st_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_CLR_REQ: begin
        cmd_o.clr_step = 1'b1;
        if (st_i.clr_last) begin
          state_d = S_DONE;
        end
      end
      S_EXEC: begin
        res_read_d   = 1'b0;
        res_status_d = st_i.addr_ok ? sri_pkg::STS_WRITE : sri_pkg::STS_REJECT;
        state_d      = S_DONE;
        case (st_i.req_type)
          sri_pkg::REQ_WR_EDGE:  cmd_o.wr_edge  = st_i.addr_ok;
          sri_pkg::REQ_WR_ROW:   cmd_o.wr_row   = st_i.addr_ok;
          sri_pkg::REQ_WR_DRIVE: cmd_o.wr_drive = st_i.addr_ok;
          sri_pkg::REQ_WR_STATE: cmd_o.wr_state = st_i.addr_ok;
          sri_pkg::REQ_RD_STATE: begin
            cmd_o.rd_state = st_i.addr_ok;
            res_read_d     = st_i.addr_ok;
            res_status_d   = st_i.addr_ok ? sri_pkg::STS_READ : sri_pkg::STS_REJECT;
          end
          sri_pkg::REQ_RUN: begin
            res_status_d = sri_pkg::STS_RUN;
            tick_cnt_d   = '0;
            if (ticks_q != 4'd0) begin
              state_d = S_T_START;
            end
          end
          sri_pkg::REQ_CLEAR: begin
            res_status_d   = sri_pkg::STS_WRITE;
            cmd_o.bank_clr = 1'b1;
            state_d        = S_CLR_REQ;
          end
          default: res_status_d = sri_pkg::STS_REJECT;
        endcase
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_read   = res_read_q;
          cmd_o.res_status = res_status_q;
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_T_START: begin
        cmd_o.tick_init = 1'b1;
        state_d         = S_ROW_RD;
      end
      S_ROW_RD: begin
        if (st_i.rows_done) begin
          state_d = S_TICK_END;
        end else begin
          cmd_o.row_rd = 1'b1;
          state_d      = S_ROW_LAT;
        end
      end
      S_ROW_LAT: begin
        cmd_o.row_latch = 1'b1;
        state_d         = S_LANE_ST;
      end
      S_LANE_ST: begin
        cmd_o.lane_init = 1'b1;
        state_d         = S_E_RD;
      end
      S_E_RD: begin
        if (st_i.edges_done) begin
          state_d = S_SCALE;
        end else begin
          cmd_o.edge_rd = 1'b1;
          state_d       = S_E_LAT;
        end
      end
      S_E_LAT: begin
        cmd_o.src_rd = 1'b1;
        state_d      = S_E_MUL;
      end
      S_E_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_E_ACC;
      end
      S_E_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = S_E_RD;
      end
      S_SCALE: begin
        if (st_i.scale_sat) begin
          cmd_o.mag_sat = 1'b1;
          state_d       = S_PRE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_SDIV;
        end
      end
      S_SDIV: begin
        if (!st_i.div_busy) begin
          cmd_o.mag_from_q = 1'b1;
          state_d          = S_PRE;
        end
      end
      S_PRE: begin
        cmd_o.pre_calc = 1'b1;
        state_d        = S_DRV;
      end
      S_DRV: begin
        cmd_o.drv_add = 1'b1;
        state_d       = S_NINIT;
      end
      S_NINIT: begin
        cmd_o.n_init = 1'b1;
        state_d      = S_NLOOP;
      end
      S_NLOOP: begin
        if (st_i.n_done) begin
          cmd_o.h_init = 1'b1;
          state_d      = S_HMUL;
        end else begin
          cmd_o.n_step = 1'b1;
        end
      end
      S_HMUL: begin
        cmd_o.h_mul = 1'b1;
        state_d     = S_HADD;
      end
      S_HADD: begin
        cmd_o.h_add = 1'b1;
        state_d     = st_i.k_zero ? S_EXP : S_HMUL;
      end
      S_EXP: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_tanh  = 1'b1;
        state_d         = S_TDIV;
      end
      S_TDIV: begin
        if (!st_i.div_busy) begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        cmd_o.wb = 1'b1;
        if (st_i.lane_last) begin
          cmd_o.row_next = 1'b1;
          state_d        = S_ROW_RD;
        end else begin
          cmd_o.lane_next = 1'b1;
          state_d         = S_LANE_ST;
        end
      end
      S_TICK_END: begin
        cmd_o.bank_flip = 1'b1;
        tick_cnt_d      = tick_cnt_q + 4'd1;
        state_d         = (tick_cnt_d >= ticks_q) ? S_DONE : S_T_START;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR_BOOT;
      ticks_q      <= sri_pkg::TICKS_RST;
      tick_cnt_q   <= '0;
      res_status_q <= sri_pkg::STS_WRITE;
      res_read_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      tick_cnt_q   <= tick_cnt_d;
      res_status_q <= res_status_d;
      res_read_q   <= res_read_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i && cfg_idx_i == sri_pkg::CFG_TICKS) begin
        ticks_q <= cfg_wdata_i[3:0];
      end
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

// ----- bench/tb_sparse_recurrent_tanh_tick.sv -----
// ----------------------------------------------------------------------------
// tb_sparse_recurrent_tanh_tick: self-checking bench of the sparse tanh tick
// Streams load, run, read and clear words with random gaps and output stalls.
// A bit-true copy of the graph update predicts every result word, and the
// results are checked in order, field by field.
// ----------------------------------------------------------------------------
module tb_sparse_recurrent_tanh_tick;
  timeunit 1ns;
  timeprecision 1ps;
  import sri_pkg::*;

  localparam logic [2:0] REQ_UNKNOWN = 3'd7;
  localparam longint     LN2_FIX     = 744261118;
  localparam longint     ONE_Q30     = 1073741824;
  localparam longint     SUM_LIM     = 64'sh4000_0000_0000_0000;
  localparam longint     CYCLE_LIMIT = 8000000;
  localparam int         LIVE_ROWS   = 16;  // rows kept well formed for runs
  localparam int         LIVE_EDGES  = 64;  // edges preloaded for live rows

  typedef struct {
    logic [2:0]  req;
    logic [15:0] addr;
    logic [2:0]  lane;
    logic [13:0] weight;
    logic [11:0] column;
    logic [16:0] rend;
    logic [30:0] rden;
    logic        hasd;
    logic [10:0] drow;
    logic [31:0] value;
  } word_t;

  typedef struct {
    logic [31:0] rdata;
    logic [1:0]  sts;
  } result_t;

  // series coefficients of exp in Q30
  localparam longint EXP_COEF [9] = '{1073741824, 1073741824, 536870912, 178956971,
                                      44739243, 8947849, 1491308, 213044, 26631};

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall_o;
  logic [2:0]         req_type = '0;
  logic [15:0]        address = '0;
  logic [2:0]         lane = '0;
  logic [13:0]        edge_weight = '0;
  logic [11:0]        edge_column = '0;
  logic [16:0]        row_end = '0;
  logic [30:0]        row_denominator = '0;
  logic               has_drive = 1'b0;
  logic [10:0]        drive_row = '0;
  logic signed [31:0] value = '0;
  logic               out_valid_o;
  logic               out_stall = 1'b0;
  logic signed [31:0] read_value_o;
  logic [1:0]         status_o;
  logic               cfg_we = 1'b0;
  logic               cfg_idx = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata = '0;

  sparse_recurrent_tanh_tick dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall_o),
    .req_type_i        (req_type),
    .address_i         (address),
    .lane_i            (lane),
    .edge_weight_i     (edge_weight),
    .edge_column_i     (edge_column),
    .row_end_i         (row_end),
    .row_denominator_i (row_denominator),
    .has_drive_i       (has_drive),
    .drive_row_i       (drive_row),
    .value_i           (value),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall),
    .read_value_o      (read_value_o),
    .status_o          (status_o),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the block: two node banks, graph stores, configuration.
  bit [31:0] node_mem [2*NODES*AGENTS];
  bit        cur_bank;
  bit [25:0] edge_mem [EDGES];
  bit [16:0] end_mem  [NODES];
  bit [30:0] den_mem  [NODES];
  bit [11:0] link_mem [NODES];
  bit [31:0] drv_mem  [DRIVE_ROWS*AGENTS];
  int        rows_per_tick = 4096;
  int        ticks_per_req = 4;

  result_t   pending [$];
  int        errors;
  longint    cycles;
  bit        idle_on = 1'b1;
  int        drive_pool [5] = '{0, 1, 2, 3, 2047};

  // ---------------------------------------------------------------------------
  // Fixed-point helpers of the predictor
  // ---------------------------------------------------------------------------
  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // tanh of a Q16.16 value: exp(-2a) by range reduction and a Taylor series
  function automatic longint tanh_fix(longint x);
    longint a, y, n, s, p, e, num, den, t;
    a = (x < 0) ? -x : x;
    if (a > 9 * 65536) a = 9 * 65536;
    y = a * 32768;
    n = (y + LN2_FIX / 2) / LN2_FIX;
    s = n * LN2_FIX - y;
    p = EXP_COEF[8];
    for (int k = 7; k >= 0; k--) p = ((p * s) >>> 30) + EXP_COEF[k];
    e = p >>> n;
    num = ONE_Q30 - e;
    if (num < 0) num = 0;
    den = ONE_Q30 + e;
    t = (num * 65536 + den / 2) / den;
    return (x < 0) ? -t : t;
  endfunction

  // one recurrent tick over the active rows, then swap banks
  task automatic advance_graph();
    int     src, dst, rows, start, stop;
    longint d, acc, m, q, mag, pre, old;
    bit     neg;
    bit [25:0] e;
    bit [11:0] link;
    src = cur_bank ? NODES * AGENTS : 0;
    dst = cur_bank ? 0 : NODES * AGENTS;
    rows = (rows_per_tick > NODES) ? NODES : rows_per_tick;
    start = 0;
    for (int r = 0; r < rows; r++) begin
      stop = (end_mem[r] > EDGES) ? EDGES : end_mem[r];
      d = (den_mem[r] == 0) ? 1 : den_mem[r];
      link = link_mem[r];
      for (int ln = 0; ln < AGENTS; ln++) begin
        acc = 0;
        for (int j = start; j < stop; j++) begin
          e = edge_mem[j];
          acc += longint'(e[25:12]) *
                 longint'($signed(node_mem[src + e[11:0] * AGENTS + ln]));
          if (acc > SUM_LIM) acc = SUM_LIM;
          if (acc < -SUM_LIM) acc = -SUM_LIM;
        end
        neg = acc < 0;
        m = neg ? -acc : acc;
        q = m / d;
        if (q >= 65536) mag = 64'sd2147483648;
        else mag = q * 32768 + ((m % d) * 32768) / d;
        pre = sat32(neg ? -mag : mag);
        if (link[11])
          pre = sat32(pre + longint'($signed(drv_mem[link[10:0] * AGENTS + ln])));
        old = longint'($signed(node_mem[src + r * AGENTS + ln]));
        node_mem[dst + r * AGENTS + ln] = 32'((old + tanh_fix(pre)) >>> 1);
      end
      if (stop > start) start = stop;
    end
    cur_bank = ~cur_bank;
  endtask

  // apply one accepted word to the shadow copy and return its result
  task automatic predict_word(input word_t w, output result_t res);
    int base;
    base = cur_bank ? NODES * AGENTS : 0;
    res.rdata = '0;
    res.sts = STS_REJECT;
    case (w.req)
      REQ_WR_EDGE: begin
        edge_mem[w.addr] = {w.weight, w.column};
        res.sts = STS_WRITE;
      end
      REQ_WR_ROW: if (w.addr < NODES) begin
        end_mem[w.addr] = w.rend;
        den_mem[w.addr] = w.rden;
        link_mem[w.addr] = w.hasd ? {1'b1, w.drow} : 12'd0;
        res.sts = STS_WRITE;
      end
      REQ_WR_DRIVE: if (w.addr < DRIVE_ROWS) begin
        drv_mem[w.addr * AGENTS + w.lane] = w.value;
        res.sts = STS_WRITE;
      end
      REQ_WR_STATE: if (w.addr < NODES) begin
        node_mem[base + w.addr * AGENTS + w.lane] = w.value;
        res.sts = STS_WRITE;
      end
      REQ_RUN: begin
        for (int t = 0; t < ticks_per_req; t++) advance_graph();
        res.sts = STS_RUN;
      end
      REQ_RD_STATE: if (w.addr < NODES) begin
        res.rdata = node_mem[base + w.addr * AGENTS + w.lane];
        res.sts = STS_READ;
      end
      REQ_CLEAR: begin
        foreach (node_mem[i]) node_mem[i] = '0;
        cur_bank = 1'b0;
        res.sts = STS_WRITE;
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  // Send one word: maybe idle first, then hold it until the handshake.
  task automatic send_word(input word_t w);
    result_t res;
    if (idle_on && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while (idle_on && $urandom_range(99) < 16);
    end
    req_type        <= w.req;
    address         <= w.addr;
    lane            <= w.lane;
    edge_weight     <= w.weight;
    edge_column     <= w.column;
    row_end         <= w.rend;
    row_denominator <= w.rden;
    has_drive       <= w.hasd;
    drive_row       <= w.drow;
    value           <= w.value;
    in_valid        <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_word(w, res);
    pending.push_back(res);
  endtask

  // drop valid and wait until every result word has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input int val);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_W'(val);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_NODE_COUNT) rows_per_tick = val;
    else ticks_per_req = val & 15;
  endtask

  // ---------------------------------------------------------------------------
  // Word builders
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] pick_value();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
    endcase
  endfunction

  function automatic logic [30:0] pick_den();
    case ($urandom_range(3))
      0: return 31'($urandom);
      1: return 31'($urandom_range(0, 4));
      2: return 31'(65536 * $urandom_range(1, 64));
      default: return 31'h7fff_ffff;
    endcase
  endfunction

  function automatic word_t blank(input logic [2:0] req, input int addr, input int ln);
    word_t w;
    w.req = req;
    w.addr = 16'(addr);
    w.lane = 3'(ln);
    w.weight = 14'($urandom);
    w.column = 12'($urandom);
    w.rend = 17'($urandom_range(0, 65536));
    w.rden = 31'($urandom);
    w.hasd = 1'($urandom);
    w.drow = 11'($urandom);
    w.value = $urandom;
    return w;
  endfunction

  // a row below LIVE_ROWS must stay inside the preloaded edges and drive pool
  function automatic word_t live_row(input int r);
    word_t w;
    w = blank(REQ_WR_ROW, r, 0);
    w.rend = 17'($urandom_range(0, LIVE_EDGES));
    w.rden = pick_den();
    w.drow = 11'(drive_pool[$urandom_range(4)]);
    return w;
  endfunction

  function automatic int pick_node();
    return ($urandom_range(3) == 0) ? $urandom_range(0, 65535)
                                    : $urandom_range(0, LIVE_ROWS - 1);
  endfunction

  function automatic word_t random_word();
    word_t w;
    int    r, a;
    r = $urandom_range(99);
    if (r < 12) begin
      w = blank(REQ_WR_EDGE, $urandom_range(1) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, LIVE_EDGES - 1), 0);
    end else if (r < 24) begin
      a = $urandom_range(1) ? $urandom_range(0, LIVE_ROWS - 1) : $urandom_range(0, 65535);
      w = (a < LIVE_ROWS) ? live_row(a) : blank(REQ_WR_ROW, a, 0);
    end else if (r < 36) begin
      a = $urandom_range(1) ? drive_pool[$urandom_range(4)] : $urandom_range(0, 65535);
      w = blank(REQ_WR_DRIVE, a, $urandom_range(7));
      w.value = pick_value();
    end else if (r < 60) begin
      w = blank(REQ_WR_STATE, pick_node(), $urandom_range(7));
      w.value = pick_value();
    end else if (r < 89) begin
      w = blank(REQ_RD_STATE, pick_node(), $urandom_range(7));
    end else if (r < 95) begin
      w = blank(REQ_RUN, $urandom_range(0, 65535), $urandom_range(7));
    end else if (r < 96) begin
      w = blank(REQ_CLEAR, $urandom_range(0, 65535), $urandom_range(7));
    end else begin
      w = blank(REQ_UNKNOWN, $urandom_range(0, 65535), $urandom_range(7));
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Load a well formed graph: edges, live rows, every lane of the drive pool.
  task automatic test_graph_load();
    word_t w;
    write_cfg(CFG_NODE_COUNT, LIVE_ROWS);
    write_cfg(CFG_TICKS, 1);
    for (int i = 0; i < LIVE_EDGES; i++) send_word(blank(REQ_WR_EDGE, i, 0));
    for (int r = 0; r < LIVE_ROWS; r++) send_word(live_row(r));
    foreach (drive_pool[p])
      for (int ln = 0; ln < AGENTS; ln++) begin
        w = blank(REQ_WR_DRIVE, drive_pool[p], ln);
        w.value = pick_value();
        send_word(w);
      end
  endtask

  // Field extremes, every request, and the named corner cases.
  task automatic test_directed();
    word_t w;
    w = blank(REQ_WR_EDGE, 65535, 0);  w.weight = '1; w.column = '1; send_word(w);
    w = blank(REQ_WR_EDGE, 0, 0);      w.weight = '1; w.column = '0; send_word(w);
    // wide rows above the active range: end at the edge store limit, max denominator
    w = blank(REQ_WR_ROW, 4095, 0);    w.rend = 17'd65536; w.rden = '1;
    w.hasd = 1'b1; w.drow = 11'd2047; send_word(w);
    w = blank(REQ_WR_ROW, 4094, 0);    w.rend = '0; w.rden = '0; w.hasd = 1'b0;
    send_word(w);
    w = blank(REQ_WR_ROW, 4096, 0);    send_word(w);
    w = blank(REQ_WR_ROW, 65535, 0);   send_word(w);
    // zero denominator and a backward end on live rows
    w = live_row(2); w.rden = '0; send_word(w);
    w = live_row(3); w.rend = '0; send_word(w);
    w = blank(REQ_WR_DRIVE, 2047, 7);  w.value = 32'h8000_0000; send_word(w);
    w = blank(REQ_WR_DRIVE, 2047, 0);  w.value = 32'h7fff_ffff; send_word(w);
    w = blank(REQ_WR_DRIVE, 2048, 3);  send_word(w);
    w = blank(REQ_WR_DRIVE, 65535, 7); send_word(w);
    w = blank(REQ_WR_STATE, 0, 0);     w.value = 32'h7fff_ffff; send_word(w);
    w = blank(REQ_WR_STATE, 1, 7);     w.value = 32'h8000_0000; send_word(w);
    w = blank(REQ_WR_STATE, 4096, 0);  send_word(w);
    w = blank(REQ_WR_STATE, 65535, 7); send_word(w);
    send_word(blank(REQ_RD_STATE, 0, 0));
    send_word(blank(REQ_RD_STATE, 4095, 7));
    send_word(blank(REQ_RD_STATE, 65535, 7));
    send_word(blank(REQ_UNKNOWN, 0, 0));
    send_word(blank(REQ_RUN, 0, 0));
    send_word(blank(REQ_RD_STATE, 0, 0));
    send_word(blank(REQ_RD_STATE, 1, 7));
    send_word(blank(REQ_CLEAR, 0, 0));
    send_word(blank(REQ_RD_STATE, 0, 0));
  endtask

  // Row counts at and past the node limit: random words with runs turned into reads.
  task automatic test_wide_count();
    word_t w;
    write_cfg(CFG_NODE_COUNT, 8191);
    for (int i = 0; i < 20; i++) begin
      w = random_word();
      if (w.req == REQ_RUN) w.req = REQ_RD_STATE;
      send_word(w);
    end
    write_cfg(CFG_NODE_COUNT, 4096);
    for (int i = 0; i < 10; i++) begin
      w = random_word();
      if (w.req == REQ_RUN) w.req = REQ_RD_STATE;
      send_word(w);
    end
  endtask

  task automatic test_random_phase(input int words, input int rows, input int ticks,
                                   input bit idle);
    write_cfg(CFG_NODE_COUNT, rows);
    write_cfg(CFG_TICKS, ticks);
    idle_on = idle;
    for (int i = 0; i < words; i++) send_word(random_word());
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (pending.size() == 0) begin
        $error("result word with nothing pending: status %0d", status_o);
        errors++;
      end else begin
        exp_res = pending.pop_front();
        if (read_value_o !== exp_res.rdata) begin
          $error("read_value: expected %0d, got %0d", $signed(exp_res.rdata), read_value_o);
          errors++;
        end
        if (status_o !== exp_res.sts) begin
          $error("status: expected %0d, got %0d", exp_res.sts, status_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) out_stall <= idle_on && ($urandom_range(99) < 16);

  // Hard stop on a hung handshake.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("sparse_recurrent_tanh_tick: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_graph_load();
    test_directed();
    test_wide_count();
    test_random_phase(60, LIVE_ROWS, 1, 1'b1);
    test_random_phase(40, 1, 15, 1'b1);
    test_random_phase(40, $urandom_range(2, 8), 0, 1'b1);
    test_random_phase(100, 8, 2, 1'b0);
    test_random_phase(35, LIVE_ROWS, 3, 1'b1);
    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending.size() == 0) begin
      $display("sparse_recurrent_tanh_tick: match");
    end else begin
      $display("sparse_recurrent_tanh_tick: mismatch");
    end
    $finish;
  end

endmodule

// ----- sparse_recurrent_tanh_tick.f -----
src/sri_pkg.sv
src/sri_div.sv
src/sri_dp.sv
src/sri_ctrl.sv
src/sparse_recurrent_tanh_tick.sv
bench/tb_sparse_recurrent_tanh_tick.sv
